// ===== hdl/ifrq_pkg.sv =====
// ----------------------------------------------------------------------------
// ifrq_pkg
// Shared types and constants of the interest filtered ready queue.
// ----------------------------------------------------------------------------
package ifrq_pkg;

   localparam int FUNC_W      = 2;
   localparam int CHAN_W      = 8;
   localparam int OCC_W       = 9;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_EVENT      = 2'd0,
      FUNC_REGISTER   = 2'd1,
      FUNC_UNREGISTER = 2'd2,
      FUNC_DEQUEUE    = 2'd3
   } func_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // per-channel flags, as held in the flag memory
   typedef struct packed {
      logic queued;
      logic interested;
      logic signalled;
   } flags_type;

endpackage

// ===== hdl/ifrq_flag_mem.sv =====
// ----------------------------------------------------------------------------
// ifrq_flag_mem
// Per-channel flag memory: one read and one write port, registered read,
// and a clearing pass over every entry after reset.
// ----------------------------------------------------------------------------
module ifrq_flag_mem #(
   parameter int NUM_CHANNELS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [$clog2(NUM_CHANNELS)-1:0]    rd_addr,
   output ifrq_pkg::flags_type                rd_data,
   input  logic                               wr_en,
   input  logic [$clog2(NUM_CHANNELS)-1:0]    wr_addr,
   input  ifrq_pkg::flags_type                wr_data,
   output logic                               clear_done
);
   import ifrq_pkg::*;

   localparam int AW = $clog2(NUM_CHANNELS);

   flags_type         flag_mem [NUM_CHANNELS];
   flags_type         flag_rd_ff;
   logic              clr_busy_ff, clr_busy_in;
   logic [AW-1:0]     clr_ptr_ff, clr_ptr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_ptr_in  = clr_ptr_ff;
      if (clr_busy_ff) begin
         if (clr_ptr_ff == AW'(NUM_CHANNELS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_ptr_in = clr_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_ptr_ff  <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         flag_mem[clr_ptr_ff] <= '0;
      end else if (wr_en) begin
         flag_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         flag_rd_ff <= flag_mem[rd_addr];
      end
   end

   assign rd_data    = flag_rd_ff;
   assign clear_done = !clr_busy_ff;

endmodule

// ===== hdl/interest_filtered_ready_queue_unit.sv =====
// ----------------------------------------------------------------------------
// interest_filtered_ready_queue_unit
// Ready queue of channel numbers filtered by per-channel interest flags.
// ----------------------------------------------------------------------------
// One word is taken at a time. On acceptance the channel's flags and the ring
// slot at the head are read from their memories; in the execute state the
// flags are modified and written back, the ring is appended or popped and the
// result register is loaded. The next word is taken while that result waits
// at the output; a result not taken by the time the next one is ready holds
// the block. After reset the flag memory is cleared one entry a cycle, so no
// word is taken until every entry has been cleared.
module interest_filtered_ready_queue_unit #(
   parameter int NUM_CHANNELS = 256,
   parameter int RING_DEPTH   = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [1:0] func, [9:2] channel, rest zero
   input  logic [ifrq_pkg::REQ_TDATA_W-1:0]       req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [7:0] ready_channel, [8] got_channel, [9] was_empty, [10] was_queued,
   // [11] overflow, [20:12] occupancy, rest zero
   output logic [ifrq_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import ifrq_pkg::*;

   localparam int AW   = $clog2(NUM_CHANNELS);
   localparam int RAW  = $clog2(RING_DEPTH);
   localparam int CNTW = $clog2(RING_DEPTH + 1);

   state_type          state_ff, state_in;
   func_type           func_ff, func_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [RAW-1:0]     head_ff, head_in;
   logic [RAW-1:0]     tail_ff, tail_in;
   logic [CNTW-1:0]    count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CHAN_W-1:0]  ring_mem [RING_DEPTH];
   logic [CHAN_W-1:0]  ring_rd_ff;

   logic               accept;
   logic               exec_go;
   logic               clear_done;
   flags_type          flags_rd;
   logic               flag_we;
   logic [AW-1:0]      flag_waddr;
   flags_type          flag_wdata;
   logic               ch_ok, pop_ok, full, app_req, do_append, do_pop;
   logic               got, empty, ovf;
   logic [CHAN_W-1:0]  ready_chan;

   assign accept  = req_tvalid && req_tready;
   assign func_in = func_type'(req_tdata[FUNC_W-1:0]);
   assign chan_in = req_tdata[FUNC_W +: CHAN_W];

   // ---- state machine ------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept)  state_in = ST_EXEC;
         ST_EXEC: if (exec_go) state_in = ST_IDLE;
         default:              state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      exec_go    = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = clear_done;
         ST_EXEC: exec_go    = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // ---- flag memory --------------------------------------------------------
   ifrq_flag_mem #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_flag_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (AW'(chan_in)),
      .rd_data    (flags_rd),
      .wr_en      (flag_we && exec_go),
      .wr_addr    (flag_waddr),
      .wr_data    (flag_wdata),
      .clear_done (clear_done)
   );

   // ---- read-modify-write of one item --------------------------------------
   assign ch_ok  = 32'(chan_ff) < 32'(NUM_CHANNELS);
   assign pop_ok = 32'(ring_rd_ff) < 32'(NUM_CHANNELS);
   assign full   = count_ff == CNTW'(RING_DEPTH);

   always_comb begin
      flag_we    = 1'b0;
      flag_waddr = AW'(chan_ff);
      flag_wdata = flags_rd;
      app_req    = 1'b0;
      do_pop     = 1'b0;
      empty      = 1'b0;
      unique case (func_ff)
         FUNC_EVENT: begin
            if (ch_ok && flags_rd.interested && !flags_rd.queued) begin
               flag_we              = 1'b1;
               flag_wdata.signalled = 1'b1;
               flag_wdata.queued    = !full;
               app_req              = 1'b1;
            end
         end
         FUNC_REGISTER: begin
            if (ch_ok && !flags_rd.interested) begin
               flag_we               = 1'b1;
               flag_wdata.interested = 1'b1;
               if (flags_rd.signalled && !flags_rd.queued) begin
                  app_req           = 1'b1;
                  flag_wdata.queued = !full;
               end
            end
         end
         FUNC_UNREGISTER: begin
            if (ch_ok) begin
               flag_we               = 1'b1;
               flag_wdata.interested = 1'b0;
            end
         end
         FUNC_DEQUEUE: begin
            if (count_ff == '0) begin
               empty = 1'b1;
            end else begin
               do_pop     = 1'b1;
               flag_we    = pop_ok;
               flag_waddr = AW'(ring_rd_ff);
               flag_wdata = '0;
            end
         end
         default: ;
      endcase
   end

   assign do_append  = app_req && !full;
   assign ovf        = app_req && full;
   assign got        = do_pop;
   assign ready_chan = do_pop ? ring_rd_ff : '0;

   // ---- ring pointers and count --------------------------------------------
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_pop) begin
         head_in  = (head_ff == RAW'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (do_append) begin
         tail_in  = (tail_ff == RAW'(RING_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && do_append) begin
         ring_mem[tail_ff] <= chan_ff;
      end
      if (accept) begin
         ring_rd_ff <= ring_mem[head_ff];
      end
   end

   // ---- result register ----------------------------------------------------
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (exec_go) begin
         rsp_data_in = RSP_TDATA_W'({OCC_W'(count_in), ovf, do_append, empty, got,
                                     ready_chan});
      end
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         func_ff <= func_in;
         chan_ff <= chan_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- assertions ---------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(RING_DEPTH))
      else $error("ring count beyond depth");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNTW'(RING_DEPTH)) |-> head_ff == tail_ff)
      else $error("ring pointers disagree with count");

   a_got_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[8] |-> !rsp_data_ff[9] && !rsp_data_ff[10]
                                         && !rsp_data_ff[11])
      else $error("dequeue result carries append or empty flags");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result raised outside execute");

endmodule
